FILE: rtl/hsvr_pkg.sv
// Shared types and constants for the HSV to RGB converter pipeline.
package hsvr_pkg;

    // Fixed-point format of hue, saturation and brightness
    localparam int FRAC_BITS = 16;
    localparam int IN_W      = FRAC_BITS + 1;
    localparam int PROD_W    = 2 * IN_W;
    localparam int CH_W      = 8;
    localparam int SCALE_W   = IN_W + CH_W;
    localparam int SECTOR_COUNT = 6;
    localparam int NSTAGES   = 5;

    localparam logic [IN_W-1:0] ONE = IN_W'(1) << FRAC_BITS;

    // Hue sector: which primary ramps up or down
    typedef enum logic [2:0] {
        SEC_RED_YEL  = 3'd0,
        SEC_YEL_GRN  = 3'd1,
        SEC_GRN_CYN  = 3'd2,
        SEC_CYN_BLU  = 3'd3,
        SEC_BLU_MAG  = 3'd4,
        SEC_MAG_RED  = 3'd5
    } t_sector;

    typedef struct packed {
        logic [IN_W-1:0] hue;
        logic [IN_W-1:0] saturation;
        logic [IN_W-1:0] brightness;
    } t_hsv;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    // Stage enables and valid bits shared by the datapath modules
    typedef struct packed {
        logic [NSTAGES-1:0] en;
        logic [NSTAGES-1:0] valid;
    } t_pipe_ctl;

    // Levels handed from the level stages to the channel stages
    typedef struct packed {
        t_sector         sector;
        logic [IN_W-1:0] v;
        logic [IN_W-1:0] p;
        logic [IN_W-1:0] q;
        logic [IN_W-1:0] t;
    } t_levels;

endpackage

FILE: rtl/hsvr_pipe_ctl.sv
// Valid bits and per-stage enables of the converter pipeline.
module hsvr_pipe_ctl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    output hsvr_pkg::t_pipe_ctl o_ctl
);

    logic [hsvr_pkg::NSTAGES-1:0] r_valid;
    logic [hsvr_pkg::NSTAGES-1:0] n_valid;
    logic [hsvr_pkg::NSTAGES-1:0] en;

    // Advance a stage when it is empty or the stage after it advances
    always_comb begin
        en[hsvr_pkg::NSTAGES-1] = !r_valid[hsvr_pkg::NSTAGES-1] || i_out_ready;
        for (int k = hsvr_pkg::NSTAGES - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    // Shift valid bits along with the data
    always_comb begin
        n_valid = r_valid;
        if (en[0]) begin
            n_valid[0] = i_in_valid;
        end
        for (int k = 1; k < hsvr_pkg::NSTAGES; k++) begin
            if (en[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ctl.en    = en;
    assign o_ctl.valid = r_valid;

    // With the consumer ready, the pipeline never pushes back
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> en[0])
        else $error("pipeline stalled with consumer ready");

    // At most one transaction enters per cycle
    a_one_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ($countones(r_valid) <= $countones($past(r_valid)) + 1))
        else $error("pipeline gained more than one transaction in a cycle");

endmodule

FILE: rtl/hsvr_level.sv
// Stages one to three: hue sector, fraction and the p, q, t levels.
module hsvr_level (
    input  logic                i_clk,
    input  hsvr_pkg::t_pipe_ctl i_ctl,
    input  hsvr_pkg::t_hsv      i_hsv,
    output hsvr_pkg::t_levels   o_levels
);

    // Stage one registers
    hsvr_pkg::t_sector                  r1_sector;
    logic [hsvr_pkg::FRAC_BITS-1:0]     r1_f;
    logic [hsvr_pkg::IN_W-1:0]          r1_s;
    logic [hsvr_pkg::IN_W-1:0]          r1_v;
    // Stage two registers
    hsvr_pkg::t_sector                  r2_sector;
    logic [hsvr_pkg::FRAC_BITS-1:0]     r2_fs;
    logic [hsvr_pkg::IN_W-1:0]          r2_ts;
    logic [hsvr_pkg::IN_W-1:0]          r2_p;
    logic [hsvr_pkg::IN_W-1:0]          r2_v;
    // Stage three registers
    hsvr_pkg::t_levels                  r3_lv;

    logic [hsvr_pkg::IN_W+2:0]          h6;
    logic [3:0]                         sec_raw;
    logic [3:0]                         sec_mod;
    logic [hsvr_pkg::IN_W-1:0]          s_sat;
    logic [hsvr_pkg::IN_W-1:0]          v_sat;
    logic [hsvr_pkg::IN_W-1:0]          nf;
    logic [hsvr_pkg::PROD_W-1:0]        fs_prod;
    logic [hsvr_pkg::PROD_W-1:0]        ts_prod;
    logic [hsvr_pkg::PROD_W-1:0]        p_prod;
    logic [hsvr_pkg::IN_W-1:0]          qm;
    logic [hsvr_pkg::IN_W-1:0]          tm;
    logic [hsvr_pkg::PROD_W-1:0]        q_prod;
    logic [hsvr_pkg::PROD_W-1:0]        t_prod;

    // Split hue into sector and fraction, clamp saturation and brightness
    always_comb begin
        h6 = ({2'b00, i_hsv.hue, 1'b0} + {i_hsv.hue, 2'b00});
        sec_raw = h6[hsvr_pkg::IN_W+2:hsvr_pkg::FRAC_BITS];
        sec_mod = (sec_raw >= 4'(hsvr_pkg::SECTOR_COUNT))
                ? sec_raw - 4'(hsvr_pkg::SECTOR_COUNT) : sec_raw;
        s_sat = (i_hsv.saturation > hsvr_pkg::ONE) ? hsvr_pkg::ONE : i_hsv.saturation;
        v_sat = (i_hsv.brightness > hsvr_pkg::ONE) ? hsvr_pkg::ONE : i_hsv.brightness;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r1_sector <= hsvr_pkg::t_sector'(sec_mod[2:0]);
            r1_f      <= h6[hsvr_pkg::FRAC_BITS-1:0];
            r1_s      <= s_sat;
            r1_v      <= v_sat;
        end
    end

    // Form f*s, (1-f)*s and p = v*(1-s)
    always_comb begin
        nf      = hsvr_pkg::ONE - {1'b0, r1_f};
        fs_prod = hsvr_pkg::PROD_W'(r1_f) * hsvr_pkg::PROD_W'(r1_s);
        ts_prod = hsvr_pkg::PROD_W'(nf) * hsvr_pkg::PROD_W'(r1_s);
        p_prod  = hsvr_pkg::PROD_W'(r1_v) * hsvr_pkg::PROD_W'(hsvr_pkg::ONE - r1_s);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r2_sector <= r1_sector;
            r2_fs     <= fs_prod[hsvr_pkg::FRAC_BITS +: hsvr_pkg::FRAC_BITS];
            r2_ts     <= ts_prod[hsvr_pkg::FRAC_BITS +: hsvr_pkg::IN_W];
            r2_p      <= p_prod[hsvr_pkg::FRAC_BITS +: hsvr_pkg::IN_W];
            r2_v      <= r1_v;
        end
    end

    // Form q = v*(1-f*s) and t = v*(1-(1-f)*s)
    always_comb begin
        qm     = hsvr_pkg::ONE - {1'b0, r2_fs};
        tm     = hsvr_pkg::ONE - r2_ts;
        q_prod = hsvr_pkg::PROD_W'(r2_v) * hsvr_pkg::PROD_W'(qm);
        t_prod = hsvr_pkg::PROD_W'(r2_v) * hsvr_pkg::PROD_W'(tm);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r3_lv.sector <= r2_sector;
            r3_lv.v      <= r2_v;
            r3_lv.p      <= r2_p;
            r3_lv.q      <= q_prod[hsvr_pkg::FRAC_BITS +: hsvr_pkg::IN_W];
            r3_lv.t      <= t_prod[hsvr_pkg::FRAC_BITS +: hsvr_pkg::IN_W];
        end
    end

    assign o_levels = r3_lv;

    // Helper levels never exceed the brightness
    a_levels_le_v: assert property (@(posedge i_clk)
        i_ctl.valid[2] |-> (r3_lv.p <= r3_lv.v && r3_lv.q <= r3_lv.v && r3_lv.t <= r3_lv.v))
        else $error("helper level above brightness");

    // Brightness stays clamped to one
    a_v_clamped: assert property (@(posedge i_clk)
        i_ctl.valid[2] |-> (r3_lv.v <= hsvr_pkg::ONE))
        else $error("brightness not clamped");

endmodule

FILE: rtl/hsvr_channel.sv
// Stages four and five: sector selection and scaling to 8-bit channels.
module hsvr_channel (
    input  logic                i_clk,
    input  hsvr_pkg::t_pipe_ctl i_ctl,
    input  hsvr_pkg::t_levels   i_levels,
    output hsvr_pkg::t_rgb      o_rgb
);

    logic [hsvr_pkg::IN_W-1:0] n_r, n_g, n_b;
    logic [hsvr_pkg::IN_W-1:0] r4_r, r4_g, r4_b;
    hsvr_pkg::t_rgb            r5_rgb;
    logic [hsvr_pkg::SCALE_W-1:0] sc_r, sc_g, sc_b;

    // Route v, p, q, t to the channels by sector
    always_comb begin
        unique case (i_levels.sector)
            hsvr_pkg::SEC_RED_YEL: begin
                n_r = i_levels.v; n_g = i_levels.t; n_b = i_levels.p;
            end
            hsvr_pkg::SEC_YEL_GRN: begin
                n_r = i_levels.q; n_g = i_levels.v; n_b = i_levels.p;
            end
            hsvr_pkg::SEC_GRN_CYN: begin
                n_r = i_levels.p; n_g = i_levels.v; n_b = i_levels.t;
            end
            hsvr_pkg::SEC_CYN_BLU: begin
                n_r = i_levels.p; n_g = i_levels.q; n_b = i_levels.v;
            end
            hsvr_pkg::SEC_BLU_MAG: begin
                n_r = i_levels.t; n_g = i_levels.p; n_b = i_levels.v;
            end
            default: begin
                n_r = i_levels.v; n_g = i_levels.p; n_b = i_levels.q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r4_r <= n_r;
            r4_g <= n_g;
            r4_b <= n_b;
        end
    end

    // Scale by 255 as (c << 8) - c and keep the integer byte
    always_comb begin
        sc_r = {r4_r, {hsvr_pkg::CH_W{1'b0}}} - hsvr_pkg::SCALE_W'(r4_r);
        sc_g = {r4_g, {hsvr_pkg::CH_W{1'b0}}} - hsvr_pkg::SCALE_W'(r4_g);
        sc_b = {r4_b, {hsvr_pkg::CH_W{1'b0}}} - hsvr_pkg::SCALE_W'(r4_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r5_rgb.red   <= sc_r[hsvr_pkg::FRAC_BITS +: hsvr_pkg::CH_W];
            r5_rgb.green <= sc_g[hsvr_pkg::FRAC_BITS +: hsvr_pkg::CH_W];
            r5_rgb.blue  <= sc_b[hsvr_pkg::FRAC_BITS +: hsvr_pkg::CH_W];
        end
    end

    assign o_rgb = r5_rgb;

endmodule

FILE: rtl/hsv_to_rgb_converter_core.sv
// HSV to RGB converter: a five-stage pipeline taking one transaction per clock
// while the consumer keeps ready high. Takes hue (Q1.16, one turn = 65536),
// saturation and brightness (Q1.16, clamped to 1.0) and returns truncated 8-bit
// red, green and blue. The five register stages are hue split, first row of
// 17x17 multipliers, second row of multipliers, sector select and scale by 255.
// Each stage holds on its own when the output stalls, so bubbles are squeezed
// out and input stays ready as long as any stage is empty. The block keeps no
// state between transactions.
module hsv_to_rgb_converter_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  hsvr_pkg::t_hsv   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output hsvr_pkg::t_rgb   o_out_data
);

    hsvr_pkg::t_pipe_ctl ctl;
    hsvr_pkg::t_levels   levels;

    // Pipeline control
    hsvr_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_ctl       (ctl)
    );

    // Sector and helper levels
    hsvr_level u_level (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_hsv    (i_in_data),
        .o_levels (levels)
    );

    // Channel select and scaling
    hsvr_channel u_channel (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_levels (levels),
        .o_rgb    (o_out_data)
    );

    assign o_in_ready  = ctl.en[0];
    assign o_out_valid = ctl.valid[hsvr_pkg::NSTAGES-1];

endmodule
